// ===== src/rcld_pkg.sv =====
// Shared types, constants and the CRC-8 step for the serial RC link deframer.
package rcld_pkg;

    // Result status codes
    localparam logic [1:0] ST_PAYLOAD = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_CRC     = 2'd2;
    localparam logic [1:0] ST_BADLEN  = 2'd3;

    // Register reset values, fixed limits and the CRC polynomial
    localparam logic [7:0] SYNC_RESET  = 8'hC8;
    localparam logic [6:0] LEN_RESET   = 7'd64;
    localparam logic [7:0] READY_RESET = 8'd131;
    localparam logic [6:0] LENGTH_CAP  = 7'd64;
    localparam logic [7:0] CRC_POLY    = 8'hD5;

    // Command passed from the parser to the emitter through the queue
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_type;
        logic [5:0] count;
        logic       link_ready;
    } t_cmd;

    // Payload store write from the parser
    typedef struct packed {
        logic       en;
        logic [5:0] addr;
        logic [7:0] data;
    } t_wr;

    // CRC-8, polynomial 0xD5, MSB first, one byte per call
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== src/rcld_front.sv =====
// Frame parser: hunts for sync, checks length and CRC, fills the payload store.
module rcld_front
    import rcld_pkg::*;
#(
    parameter int FRAME_STORE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_line_gap,
    input  logic [7:0] i_sync_value,
    input  logic [6:0] i_max_length,
    input  logic [7:0] i_ready_threshold,
    input  logic       i_q_full,
    input  logic       i_q_empty,
    input  logic       i_back_idle,
    output logic       o_push,
    output t_cmd       o_cmd,
    output t_wr        o_wr
);

    localparam int CAP_INT = (FRAME_STORE_DEPTH + 2 < 64) ? FRAME_STORE_DEPTH + 2 : 64;
    localparam logic [6:0] STORE_CAP = 7'(CAP_INT);

    localparam logic [1:0] PH_SYNC = 2'd0;
    localparam logic [1:0] PH_LEN  = 2'd1;
    localparam logic [1:0] PH_TYPE = 2'd2;
    localparam logic [1:0] PH_BODY = 2'd3;

    logic [1:0] r_phase, n_phase;
    logic [6:0] r_len, n_len;
    logic [6:0] r_seen, n_seen;
    logic [7:0] r_crc, n_crc;
    logic [7:0] r_type, n_type;
    logic [7:0] r_count, n_count;

    logic       accept;
    logic [6:0] eff_max;
    logic [7:0] count_inc;
    logic [6:0] n_payload;

    // Body bytes wait until the emitter has finished with the store
    assign o_ready = !i_q_full && (r_phase != PH_BODY || (i_q_empty && i_back_idle));
    assign accept  = i_valid && o_ready;

    // Effective maximum length, bounded by the length cap and the store size
    always_comb begin
        eff_max = i_max_length;
        if (eff_max > LENGTH_CAP) begin
            eff_max = LENGTH_CAP;
        end
        if (eff_max > STORE_CAP) begin
            eff_max = STORE_CAP;
        end
    end

    assign count_inc = (r_count == 8'hFF) ? r_count : r_count + 8'd1;
    assign n_payload = r_len - 7'd2;

    // Next-state and command generation
    always_comb begin
        n_phase = r_phase;
        n_len   = r_len;
        n_seen  = r_seen;
        n_crc   = r_crc;
        n_type  = r_type;
        n_count = r_count;
        o_push  = 1'b0;
        o_cmd   = '0;
        o_wr    = '0;
        if (accept) begin
            if (i_line_gap) begin
                n_phase = PH_SYNC;
            end else begin
                case (r_phase)
                    PH_SYNC: begin
                        if (i_data_byte == i_sync_value) begin
                            n_phase = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        if (i_data_byte < 8'd2 || i_data_byte > {1'b0, eff_max}) begin
                            n_phase          = PH_SYNC;
                            o_push           = 1'b1;
                            o_cmd.status     = ST_BADLEN;
                            o_cmd.link_ready = (r_count > i_ready_threshold);
                        end else begin
                            n_len   = i_data_byte[6:0];
                            n_phase = PH_TYPE;
                        end
                    end
                    PH_TYPE: begin
                        n_type  = i_data_byte;
                        n_crc   = crc8_step(8'd0, i_data_byte);
                        n_seen  = 7'd1;
                        n_phase = PH_BODY;
                    end
                    PH_BODY: begin
                        if ({1'b0, r_seen} + 8'd1 < {1'b0, r_len}) begin
                            o_wr.en   = 1'b1;
                            o_wr.addr = 6'(r_seen - 7'd1);
                            o_wr.data = i_data_byte;
                            n_crc     = crc8_step(r_crc, i_data_byte);
                            n_seen    = r_seen + 7'd1;
                        end else begin
                            n_phase          = PH_SYNC;
                            o_push           = 1'b1;
                            o_cmd.frame_type = r_type;
                            if (i_data_byte != r_crc) begin
                                o_cmd.status     = ST_CRC;
                                o_cmd.link_ready = (r_count > i_ready_threshold);
                            end else begin
                                n_count          = count_inc;
                                o_cmd.status     = (n_payload == 7'd0) ? ST_EMPTY : ST_PAYLOAD;
                                o_cmd.count      = n_payload[5:0];
                                o_cmd.link_ready = (count_inc > i_ready_threshold);
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_SYNC;
                    end
                endcase
            end
        end
    end

    // Parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SYNC;
            r_len   <= '0;
            r_seen  <= '0;
            r_crc   <= '0;
            r_type  <= '0;
            r_count <= '0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_seen  <= n_seen;
            r_crc   <= n_crc;
            r_type  <= n_type;
            r_count <= n_count;
        end
    end

endmodule

// ===== src/rcld_fifo.sv =====
// Two-entry command queue between the parser and the emitter.
module rcld_fifo
    import rcld_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_cmd,
    output logic o_empty,
    output logic o_full
);

    t_cmd       r_slot [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_cmd   = r_slot[r_rp];
    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_cmd;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

// ===== src/rcld_back.sv =====
// Result emitter: holds the payload store and plays out each queued command.
module rcld_back
    import rcld_pkg::*;
#(
    parameter int FRAME_STORE_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_wr        i_wr,
    input  t_cmd       i_cmd,
    input  logic       i_q_empty,
    output logic       o_pop,
    output logic       o_idle,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_status,
    output logic [7:0] o_frame_type,
    output logic [7:0] o_payload_byte,
    output logic [5:0] o_byte_index,
    output logic       o_last,
    output logic       o_link_ready
);

    localparam int AW = $clog2(FRAME_STORE_DEPTH);
    localparam int IW = (AW > 6) ? AW : 6;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_READ = 2'd1;
    localparam logic [1:0] B_LOAD = 2'd2;

    logic [7:0]    r_store [FRAME_STORE_DEPTH];
    logic [7:0]    r_rd;
    logic [1:0]    r_bstate;
    t_cmd          r_cmd;
    logic [5:0]    r_idx;
    logic [IW-1:0] wr_ext;
    logic [IW-1:0] rd_ext;
    logic          out_free;
    logic          idx_last;

    assign wr_ext   = IW'(i_wr.addr);
    assign rd_ext   = IW'(r_idx);
    assign out_free = !o_valid || i_ready;
    assign idx_last = ({1'b0, r_idx} + 7'd1 == {1'b0, r_cmd.count});
    assign o_idle   = (r_bstate == B_IDLE);
    assign o_pop    = (r_bstate == B_IDLE) && !i_q_empty
                      && (i_cmd.status == ST_PAYLOAD || out_free);

    // Payload store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_store[wr_ext[AW-1:0]] <= i_wr.data;
        end
        r_rd <= r_store[rd_ext[AW-1:0]];
    end

    // Command sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate <= B_IDLE;
            r_idx    <= '0;
        end else begin
            case (r_bstate)
                B_IDLE: begin
                    if (o_pop && i_cmd.status == ST_PAYLOAD) begin
                        r_idx    <= '0;
                        r_bstate <= B_READ;
                    end
                end
                B_READ: begin
                    r_bstate <= B_LOAD;
                end
                B_LOAD: begin
                    if (out_free) begin
                        r_idx    <= r_idx + 6'd1;
                        r_bstate <= idx_last ? B_IDLE : B_READ;
                    end
                end
                default: begin
                    r_bstate <= B_IDLE;
                end
            endcase
        end
    end

    // Command held while its payload is played out
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (out_free) begin
            o_valid <= (o_pop && i_cmd.status != ST_PAYLOAD) || (r_bstate == B_LOAD);
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_bstate == B_LOAD) begin
                o_status       <= ST_PAYLOAD;
                o_frame_type   <= r_cmd.frame_type;
                o_payload_byte <= r_rd;
                o_byte_index   <= r_idx;
                o_last         <= idx_last;
                o_link_ready   <= r_cmd.link_ready;
            end else if (o_pop) begin
                o_status       <= i_cmd.status;
                o_frame_type   <= i_cmd.frame_type;
                o_payload_byte <= '0;
                o_byte_index   <= '0;
                o_last         <= 1'b1;
                o_link_ready   <= i_cmd.link_ready;
            end
        end
    end

endmodule

// ===== src/serial_rc_link_deframer.sv =====
// Top level of the serial RC link deframer: register port, parser, queue and emitter.
//
// Received bytes enter on the slave stream: tdata carries the byte and tuser
// marks an idle gap, which drops any partial frame. Frames start with the
// sync byte, followed by a length, a type, the payload and a CRC-8 byte.
// Results leave on the master stream: one per payload byte of a good frame,
// or a single result for an empty frame, a CRC error or a bad length, with
// tlast on the final result of each frame and the status code in tuser.
// A single result passes through the queue and then the output register after
// the byte that closes its frame; payload results pass through the queue, then
// the registered store read and the output register, one store read for each
// payload byte ahead of the output register. Body bytes of the next frame
// wait until the previous payload has been played out; sync, length and type bytes
// are still taken while fewer than two commands are queued.
// When the receiver stalls, the output register holds its result and the
// stall backs up through the queue to the input. Reset returns the parser
// to sync hunting, empties the queue, clears the good-frame count and loads
// the register defaults; the payload store is not cleared.
// The register port is always ready and writes on the access cycle.
module serial_rc_link_deframer
    import rcld_pkg::*;
#(
    parameter int FRAME_STORE_DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input byte stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tuser,   // [0] line_gap
    // Result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [7:0] frame_type, [15:8] payload_byte,
                                     // [21:16] byte_index, [22] link_ready
    output logic [1:0]  o_m_tuser,   // [1:0] status
    output logic        o_m_tlast,
    // Register port
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output logic [31:0] o_prdata,
    output logic        o_pready
);

    localparam logic [1:0] REG_SYNC  = 2'd0;
    localparam logic [1:0] REG_MAXL  = 2'd1;
    localparam logic [1:0] REG_READY = 2'd2;

    logic [7:0] r_sync_value;
    logic [6:0] r_max_length;
    logic [7:0] r_ready_threshold;

    logic       cfg_wr;
    logic       push;
    logic       pop;
    logic       q_full;
    logic       q_empty;
    logic       back_idle;
    t_cmd       push_cmd;
    t_cmd       head_cmd;
    t_wr        store_wr;
    logic [7:0] frame_type;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       link_ready;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_value      <= SYNC_RESET;
            r_max_length      <= LEN_RESET;
            r_ready_threshold <= READY_RESET;
        end else if (cfg_wr) begin
            case (i_paddr[3:2])
                REG_SYNC:  r_sync_value      <= i_pwdata[7:0];
                REG_MAXL:  r_max_length      <= i_pwdata[6:0];
                REG_READY: r_ready_threshold <= i_pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back
    always_comb begin
        case (i_paddr[3:2])
            REG_SYNC:  o_prdata = {24'd0, r_sync_value};
            REG_MAXL:  o_prdata = {25'd0, r_max_length};
            REG_READY: o_prdata = {24'd0, r_ready_threshold};
            default:   o_prdata = '0;
        endcase
    end

    rcld_front #(
        .FRAME_STORE_DEPTH(FRAME_STORE_DEPTH)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_s_tvalid),
        .o_ready          (o_s_tready),
        .i_data_byte      (i_s_tdata),
        .i_line_gap       (i_s_tuser),
        .i_sync_value     (r_sync_value),
        .i_max_length     (r_max_length),
        .i_ready_threshold(r_ready_threshold),
        .i_q_full         (q_full),
        .i_q_empty        (q_empty),
        .i_back_idle      (back_idle),
        .o_push           (push),
        .o_cmd            (push_cmd),
        .o_wr             (store_wr)
    );

    rcld_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .i_pop  (pop),
        .o_cmd  (head_cmd),
        .o_empty(q_empty),
        .o_full (q_full)
    );

    rcld_back #(
        .FRAME_STORE_DEPTH(FRAME_STORE_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_wr          (store_wr),
        .i_cmd         (head_cmd),
        .i_q_empty     (q_empty),
        .o_pop         (pop),
        .o_idle        (back_idle),
        .o_valid       (o_m_tvalid),
        .i_ready       (i_m_tready),
        .o_status      (o_m_tuser),
        .o_frame_type  (frame_type),
        .o_payload_byte(payload_byte),
        .o_byte_index  (byte_index),
        .o_last        (o_m_tlast),
        .o_link_ready  (link_ready)
    );

    assign o_m_tdata = {1'b0, link_ready, byte_index, payload_byte, frame_type};

endmodule

// ===== src/rcld_checker.sv =====
// Port-level checks on the deframer, bound to the top level.
module rcld_checker
    import rcld_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        o_m_tlast
);

    // A stalled result stays offered and unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result changed while stalled");

    // Empty, CRC and length results close their frame on their own
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_PAYLOAD |-> o_m_tlast)
        else $error("non-payload result without tlast");

    // Only payload results carry a byte and an index
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != ST_PAYLOAD |-> o_m_tdata[21:8] == 14'd0)
        else $error("non-payload result carries payload fields");

    // A bad length result has no frame type
    a_badlen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_BADLEN |-> o_m_tdata[7:0] == 8'd0)
        else $error("bad length result with a frame type");

endmodule

bind serial_rc_link_deframer rcld_checker u_rcld_checker (.*);
